// ===== hw/rtl/piecewise_linear_curve_lookup_defines.svh =====
// Assertion macros shared by the curve lookup RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/plcl_pkg.sv =====
// Shared types and constants for the piecewise-linear curve lookup.
// No dependencies; imported by plcl_div and the top level.
package plcl_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int HALF_PTS   = MAX_POINTS / 2;

  // Divider: 16-bit product over 8-bit span, 8-bit quotient.
  localparam int QUO_W      = 8;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEP   = QUO_W / DIV_STAGES;

  // Configuration register indexes
  localparam logic [2:0] REG_POINTS_USED = 3'd0;
  localparam logic [2:0] REG_X_LOW       = 3'd1;
  localparam logic [2:0] REG_X_HIGH      = 3'd2;
  localparam logic [2:0] REG_Y_LOW       = 3'd3;
  localparam logic [2:0] REG_Y_HIGH      = 3'd4;
  localparam logic [2:0] REG_BELOW       = 3'd5;
  localparam logic [2:0] REG_ABOVE       = 3'd6;

  typedef enum logic [1:0] {
    REGION_BELOW  = 2'd0,
    REGION_INSIDE = 2'd1,
    REGION_ABOVE  = 2'd2
  } region_t;

  // Sideband that rides along with the divider.
  typedef struct packed {
    logic        valid;
    region_t     region;
    logic        use_fixed;
    logic        neg;
    logic [7:0]  y1;
    logic [7:0]  fixed;
  } plcl_side_t;

endpackage

// ===== hw/rtl/piecewise_linear_curve_lookup.sv =====
// Piecewise-linear curve lookup: maps an 8-bit x through up to 16 breakpoints.
// An x value is answered through segment search, offset and product, four
// divider stages (two quotient bits each) and the output register; one request
// can be taken every cycle while the output is not stalled. The pipeline
// advances as a whole; it stops only while a result waits at the output.
// Below the first breakpoint the result is below_value with region 0, above
// the last it is above_value with region 2, otherwise the interpolated or
// segment end value with region 1. Write configuration only while no request
// is in flight. Depends on plcl_pkg, plcl_div and the assertion macro header.
`include "piecewise_linear_curve_lookup_defines.svh"

module piecewise_linear_curve_lookup
  import plcl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] x_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] y_value
  output logic [1:0]  out_tuser,  // [1:0] region
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Configuration registers
  logic [4:0]  points_used_r;
  logic [63:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic [7:0]  below_value_r, above_value_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_used_r <= 5'd2;
      x_low_r       <= '0;
      x_high_r      <= '0;
      y_low_r       <= '0;
      y_high_r      <= '0;
      below_value_r <= 8'd55;
      above_value_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POINTS_USED: points_used_r <= cfg_data[4:0];
        REG_X_LOW:       x_low_r       <= cfg_data;
        REG_X_HIGH:      x_high_r      <= cfg_data;
        REG_Y_LOW:       y_low_r       <= cfg_data;
        REG_Y_HIGH:      y_high_r      <= cfg_data;
        REG_BELOW:       below_value_r <= cfg_data[7:0];
        REG_ABOVE:       above_value_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] xb [MAX_POINTS];
  logic [7:0] yb [MAX_POINTS];

  always_comb begin
    for (int i = 0; i < HALF_PTS; i++) begin
      xb[i]            = x_low_r[i*8 +: 8];
      xb[i + HALF_PTS] = x_high_r[i*8 +: 8];
      yb[i]            = y_low_r[i*8 +: 8];
      yb[i + HALF_PTS] = y_high_r[i*8 +: 8];
    end
  end

  // Whole-pipeline advance
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- Stage 1: segment search
  logic [IDX_W-1:0] last_idx, seg_idx;
  logic [7:0]       x_in;
  region_t          region_nxt;

  assign x_in = in_tdata[7:0];

  always_comb begin
    if (points_used_r < 5'd2) begin
      last_idx = IDX_W'(1);
    end else if (points_used_r > 5'(MAX_POINTS)) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(points_used_r - 5'd1);
    end
    // first breakpoint above x, clamped to the last segment
    seg_idx = last_idx;
    for (int i = MAX_POINTS - 2; i >= 1; i--) begin
      if ((x_in < xb[i]) && (IDX_W'(i) < last_idx)) begin
        seg_idx = IDX_W'(i);
      end
    end
    if (x_in < xb[0]) begin
      region_nxt = REGION_BELOW;
    end else if (x_in > xb[last_idx]) begin
      region_nxt = REGION_ABOVE;
    end else begin
      region_nxt = REGION_INSIDE;
    end
  end

  logic       s1_valid_r;
  region_t    s1_region_r;
  logic [7:0] s1_x_r, s1_x1_r, s1_x2_r, s1_y1_r, s1_y2_r, s1_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_region_r <= region_nxt;
      s1_x_r      <= x_in;
      s1_x1_r     <= xb[seg_idx - IDX_W'(1)];
      s1_x2_r     <= xb[seg_idx];
      s1_y1_r     <= yb[seg_idx - IDX_W'(1)];
      s1_y2_r     <= yb[seg_idx];
      s1_clamp_r  <= (region_nxt == REGION_BELOW) ? below_value_r : above_value_r;
    end
  end

  // ---------------- Stage 2: offset, span, magnitude and product
  plcl_side_t  side_nxt;
  logic [15:0] prod_nxt;
  logic [7:0]  span, offset, mag;

  always_comb begin
    span   = s1_x2_r - s1_x1_r;
    offset = s1_x_r - s1_x1_r;
    side_nxt.valid     = s1_valid_r;
    side_nxt.region    = s1_region_r;
    side_nxt.y1        = s1_y1_r;
    side_nxt.neg       = !(s1_y1_r < s1_y2_r);
    mag = side_nxt.neg ? (s1_y1_r - s1_y2_r) : (s1_y2_r - s1_y1_r);
    side_nxt.use_fixed = 1'b1;
    side_nxt.fixed     = s1_y1_r;
    if (s1_region_r != REGION_INSIDE) begin
      side_nxt.fixed = s1_clamp_r;
    end else if (s1_x_r < s1_x1_r) begin
      side_nxt.fixed = s1_y1_r;
    end else if (s1_x_r > s1_x2_r) begin
      side_nxt.fixed = s1_y2_r;
    end else if (span != 8'd0) begin
      side_nxt.use_fixed = 1'b0;
    end
    prod_nxt = {8'd0, mag} * {8'd0, offset};
  end

  plcl_side_t  s2_side_r;
  logic [15:0] s2_prod_r;
  logic [7:0]  s2_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r <= '0;
    end else if (en) begin
      s2_side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod_r <= prod_nxt;
      s2_span_r <= span;
    end
  end

  // ---------------- Stages 3..6: divide
  plcl_side_t div_side;
  logic [7:0] div_quot;

  plcl_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_side     (s2_side_r),
    .in_dividend (s2_prod_r),
    .in_divisor  (s2_span_r),
    .out_side    (div_side),
    .out_quot    (div_quot)
  );

  // ---------------- Stage 7: output register
  logic [7:0] y_nxt;
  logic [7:0] y_r;
  region_t    region_r;

  always_comb begin
    if (div_side.use_fixed) begin
      y_nxt = div_side.fixed;
    end else if (div_side.neg) begin
      y_nxt = div_side.y1 - div_quot;
    end else begin
      y_nxt = div_side.y1 + div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r      <= y_nxt;
      region_r <= div_side.region;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = y_r;
  assign out_tuser  = region_r;

  `PLCL_ASSERT_NOW(a_below_value, clk, rst_n, out_valid_r && (region_r == REGION_BELOW), y_r == below_value_r, "below region must return below_value")
  `PLCL_ASSERT_NOW(a_above_value, clk, rst_n, out_valid_r && (region_r == REGION_ABOVE), y_r == above_value_r, "above region must return above_value")
  `PLCL_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid_r && !out_tready, (y_r == $past(y_r)) && (region_r == $past(region_r)) && (s1_valid_r == $past(s1_valid_r)), "stalled pipeline must not advance")

endmodule

// ===== hw/rtl/plcl_div.sv =====
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// Depends on plcl_pkg for widths and the sideband struct.
module plcl_div
  import plcl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  plcl_side_t         in_side,
  input  logic [2*QUO_W-1:0] in_dividend,
  input  logic [QUO_W-1:0]   in_divisor,
  output plcl_side_t         out_side,
  output logic [QUO_W-1:0]   out_quot
);

  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] dvs;
  } plcl_div_t;

  plcl_div_t  stage_r   [DIV_STAGES];
  plcl_div_t  stage_nxt [DIV_STAGES];
  plcl_side_t side_r    [DIV_STAGES];

  function automatic plcl_div_t div_steps(plcl_div_t s);
    plcl_div_t  o;
    logic [QUO_W:0] t;
    o = s;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {o.rem, o.low[QUO_W-1]};
      o.low = {o.low[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, o.dvs}) begin
        o.rem = QUO_W'(t - {1'b0, o.dvs});
        o.quo = {o.quo[QUO_W-2:0], 1'b1};
      end else begin
        o.rem = t[QUO_W-1:0];
        o.quo = {o.quo[QUO_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // The quotient never exceeds QUO_W bits when it is used, so the
  // upper half of the dividend seeds the partial remainder.
  always_comb begin
    plcl_div_t first;
    first.rem = in_dividend[2*QUO_W-1:QUO_W];
    first.low = in_dividend[QUO_W-1:0];
    first.quo = '0;
    first.dvs = in_divisor;
    stage_nxt[0] = div_steps(first);
    for (int k = 1; k < DIV_STAGES; k++) begin
      stage_nxt[k] = div_steps(stage_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        side_r[k] <= '0;
      end
    end else if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign out_side = side_r[DIV_STAGES-1];
  assign out_quot = stage_r[DIV_STAGES-1].quo;

endmodule

// ===== verif/tb_piecewise_linear_curve_lookup.sv =====
// Self-checking testbench for piecewise_linear_curve_lookup: a directed table,
// then random curves and x values, mostly under random stalls on both streams.
// Depends on plcl_pkg and the block's RTL.
module tb_piecewise_linear_curve_lookup;
  import plcl_pkg::*;

  localparam int          TIMEOUT_CYCLES = 200000;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          PHASE_ITEMS    = 72;
  localparam logic [2:0]  REG_UNUSED     = 3'd7;

  typedef struct packed {
    logic [7:0] y;
    logic [1:0] region;
  } curve_result_t;

  typedef struct {
    int unsigned setting;
    logic [7:0]  x;
    bit          typed;
    logic [7:0]  y;
    region_t     region;
  } probe_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] x_value
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] y_value
  logic [1:0]  out_tuser;   // [1:0] region
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // Local copy of the curve registers, at their reset values
  logic [4:0]  curve_points = 5'd2;
  logic [63:0] curve_xlo    = '0;
  logic [63:0] curve_xhi    = '0;
  logic [63:0] curve_ylo    = '0;
  logic [63:0] curve_yhi    = '0;
  logic [7:0]  curve_below  = 8'd55;
  logic [7:0]  curve_above  = 8'd0;

  curve_result_t pending_results[$];
  int            fails    = 0;
  bit            idle_on  = 1'b1;
  bit            hold_req = 1'b0;

  probe_row_t probes [26] = '{
    // reset curve: both breakpoints at x = 0
    '{0, 8'h00, 1, 8'h00, REGION_INSIDE},
    '{0, 8'hFF, 1, 8'h00, REGION_ABOVE},
    '{0, 8'h80, 1, 8'h00, REGION_ABOVE},
    // 16 sorted points, rising and falling segments, y extremes
    '{1, 8'h00, 1, 8'hAA, REGION_BELOW},
    '{1, 8'h0F, 1, 8'hAA, REGION_BELOW},
    '{1, 8'h10, 0, 8'h00, REGION_BELOW},
    '{1, 8'h18, 0, 8'h00, REGION_BELOW},
    '{1, 8'h2F, 0, 8'h00, REGION_BELOW},
    '{1, 8'h30, 0, 8'h00, REGION_BELOW},
    '{1, 8'h38, 0, 8'h00, REGION_BELOW},
    '{1, 8'h7F, 0, 8'h00, REGION_BELOW},
    '{1, 8'h88, 0, 8'h00, REGION_BELOW},
    '{1, 8'hEF, 0, 8'h00, REGION_BELOW},
    '{1, 8'hF0, 0, 8'h00, REGION_BELOW},
    '{1, 8'hF1, 1, 8'h55, REGION_ABOVE},
    '{1, 8'hFF, 1, 8'h55, REGION_ABOVE},
    // point count 0 clamps to 2; both points equal gives a zero span
    '{2, 8'h3F, 1, 8'h00, REGION_BELOW},
    '{2, 8'h40, 0, 8'h00, REGION_BELOW},
    '{2, 8'h41, 1, 8'hFF, REGION_ABOVE},
    // point count 31 clamps to 16; unsorted x, zero span in the last segment
    '{3, 8'h07, 1, 8'h01, REGION_BELOW},
    '{3, 8'h08, 0, 8'h00, REGION_BELOW},
    '{3, 8'h50, 0, 8'h00, REGION_BELOW},
    '{3, 8'h9F, 0, 8'h00, REGION_BELOW},
    '{3, 8'hF0, 0, 8'h00, REGION_BELOW},
    '{3, 8'hF1, 1, 8'hFE, REGION_ABOVE},
    '{3, 8'hFF, 1, 8'hFE, REGION_ABOVE}
  };

  piecewise_linear_curve_lookup DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] point_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input int unsigned i);
    logic [3:0]  k;
    logic [63:0] w;
    k = i[3:0];
    w = k[3] ? hi : lo;
    return w[8*k[2:0] +: 8];
  endfunction

  function automatic curve_result_t curve_at(input logic [7:0] x);
    int unsigned   n, c, x1, x2, y1, y2, span, step;
    curve_result_t r;
    n = curve_points;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (x < point_byte(curve_xlo, curve_xhi, 0)) begin
      r.y = curve_below;
      r.region = REGION_BELOW;
    end else if (x > point_byte(curve_xlo, curve_xhi, n - 1)) begin
      r.y = curve_above;
      r.region = REGION_ABOVE;
    end else begin
      c = 1;
      while (c < n - 1 && x >= point_byte(curve_xlo, curve_xhi, c)) c++;
      x1 = point_byte(curve_xlo, curve_xhi, c - 1);
      x2 = point_byte(curve_xlo, curve_xhi, c);
      y1 = point_byte(curve_ylo, curve_yhi, c - 1);
      y2 = point_byte(curve_ylo, curve_yhi, c);
      span = x2 - x1;
      if (x < x1) begin
        r.y = y1[7:0];
      end else if (x > x2) begin
        r.y = y2[7:0];
      end else if (span == 0) begin
        r.y = y1[7:0];
      end else if (y1 < y2) begin
        step = ((y2 - y1) * (x - x1)) / span;
        r.y = 8'(y1 + step);
      end else begin
        step = ((y1 - y2) * (x - x1)) / span;
        r.y = 8'(y1 - step);
      end
      r.region = REGION_INSIDE;
    end
    return r;
  endfunction

  // Byte with a bias toward 0 and 255
  function automatic logic [7:0] extreme_byte();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Half the time near a breakpoint, otherwise anywhere
  function automatic logic [7:0] pick_x();
    int tmp;
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    tmp = int'(point_byte(curve_xlo, curve_xhi, $urandom_range(0, 15)))
          + int'($urandom_range(0, 2)) - 1;
    return tmp[7:0];
  endfunction

  // Called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POINTS_USED: curve_points = val[4:0];
      REG_X_LOW:       curve_xlo    = val;
      REG_X_HIGH:      curve_xhi    = val;
      REG_Y_LOW:       curve_ylo    = val;
      REG_Y_HIGH:      curve_yhi    = val;
      REG_BELOW:       curve_below  = val[7:0];
      REG_ABOVE:       curve_above  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_x(input logic [7:0] x, input bit typed, input curve_result_t typed_res);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = x;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(typed ? typed_res : curve_at(x));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input int unsigned s);
    case (s)
      1: begin
        write_reg(REG_POINTS_USED, 64'd16);
        write_reg(REG_X_LOW,  64'h7060_5040_3030_2010);
        write_reg(REG_X_HIGH, 64'hF0E0_D0C0_B0A0_9080);
        write_reg(REG_Y_LOW,  64'h4000_FF20_1080_FF00);
        write_reg(REG_Y_HIGH, 64'h7F80_01FF_0090_9041);
        write_reg(REG_BELOW,  64'hAA);
        write_reg(REG_ABOVE,  64'h55);
      end
      2: begin
        write_reg(REG_POINTS_USED, 64'd0);
        write_reg(REG_X_LOW,  64'h0000_0000_0000_4040);
        write_reg(REG_Y_LOW,  64'h0000_0000_0000_7733);
        write_reg(REG_BELOW,  64'h00);
        write_reg(REG_ABOVE,  64'hFF);
        // index past the register list must change nothing
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      end
      3: begin
        write_reg(REG_POINTS_USED, 64'd31);
        write_reg(REG_X_LOW,  64'h3050_A010_6020_8008);
        write_reg(REG_X_HIGH, 64'hF0F0_E0C0_B090_7040);
        write_reg(REG_Y_LOW,  64'h0123_4567_89AB_CDEF);
        write_reg(REG_Y_HIGH, 64'hFEDC_BA98_7654_3210);
        write_reg(REG_BELOW,  64'h01);
        write_reg(REG_ABOVE,  64'hFE);
      end
      default: ;
    endcase
  endtask

  // New random curve, then a burst of x values against it
  task automatic run_phase(input int unsigned pts, input bit sorted, input int unsigned count);
    logic [63:0]   xs [2];
    logic [63:0]   ys [2];
    int unsigned   acc;
    curve_result_t none;
    none = '0;
    drain();
    acc = $urandom_range(0, 24);
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (sorted) xs[i / 8][8*(i % 8) +: 8] = (acc > 255) ? 8'hFF : acc[7:0];
      else        xs[i / 8][8*(i % 8) +: 8] = extreme_byte();
      ys[i / 8][8*(i % 8) +: 8] = extreme_byte();
      acc += $urandom_range(0, 30);
    end
    write_reg(REG_POINTS_USED, 64'(pts));
    write_reg(REG_X_LOW,  xs[0]);
    write_reg(REG_X_HIGH, xs[1]);
    write_reg(REG_Y_LOW,  ys[0]);
    write_reg(REG_Y_HIGH, ys[1]);
    write_reg(REG_BELOW,  64'(extreme_byte()));
    write_reg(REG_ABOVE,  64'(extreme_byte()));
    repeat (count) send_x(pick_x(), 1'b0, none);
  endtask

  // Result side: random back-pressure, one long hold on request
  initial begin
    int unsigned   gap;
    curve_result_t got, want;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.y = out_tdata;
      got.region = out_tuser;
      if (pending_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: y=%h region=%0d", got.y, got.region);
      end else begin
        want = pending_results.pop_front();
        if (got.y !== want.y || got.region !== want.region) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected y=%h region=%0d, got y=%h region=%0d",
                     want.y, want.region, got.y, got.region);
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    int unsigned   cur;
    curve_result_t typed_res;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    cur = 0;
    foreach (probes[i]) begin
      if (probes[i].setting != cur) begin
        drain();
        cur = probes[i].setting;
        apply_setting(cur);
      end
      typed_res.y = probes[i].y;
      typed_res.region = probes[i].region;
      send_x(probes[i].x, probes[i].typed, typed_res);
    end

    idle_on = 1'b1;
    run_phase(2, 1'b1, PHASE_ITEMS);
    idle_on = 1'b0;
    run_phase(16, 1'b1, PHASE_ITEMS);
    idle_on = 1'b1;
    run_phase(0, 1'b1, PHASE_ITEMS);
    run_phase(31, 1'b1, PHASE_ITEMS);
    // full-rate input against a long output stall fills the pipeline
    idle_on = 1'b0;
    hold_req = 1'b1;
    run_phase(16, 1'b1, PHASE_ITEMS);
    idle_on = 1'b1;
    run_phase($urandom_range(2, 16), 1'b0, PHASE_ITEMS);
    run_phase($urandom_range(2, 16), 1'b1, PHASE_ITEMS);
    run_phase($urandom_range(0, 31), 1'b1, PHASE_ITEMS);
    drain();

    fails += pending_results.size();
    if (fails == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("Mismatches found");
    $finish;
  end

endmodule
